// File: hw/rtl/spv_pkg.sv
package spv_pkg;

  localparam int BASE_SIZE_DEF = 64;
  localparam int CAND_BITS_DEF = 17;

  localparam int PRIME_W   = 10;
  localparam int SLOT_W    = 6;
  localparam int CAND_W    = 17;
  localparam int PAR_W     = 64;
  localparam int COF_W     = 35;
  localparam int N_W       = 32;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int RADIX     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_N_VALUE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_COUNT = 2'd1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic [PRIME_W-1:0] prime;
    logic [CAND_W-1:0] candidate;
  } in_item_t;

  typedef struct packed {
    logic              smooth;
    logic [PAR_W-1:0]  parity_bits;
    logic [COF_W-1:0]  cofactor;
    logic [CAND_W-1:0] candidate_echo;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [N_W-1:0]       data;
  } cfg_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_COL,
    ST_PRIME,
    ST_DIVST,
    ST_DIVRUN,
    ST_CHECK,
    ST_NEXT,
    ST_DONE,
    ST_RET
  } step_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_TEST,
    C_MAG_ZERO,
    C_COL_END,
    C_PRIME_BAD,
    C_DIV_BUSY,
    C_DIV_MORE,
    C_OUT_FULL
  } cond_e;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic sub_en;
    logic rd_en;
    logic div_start;
    logic div_step;
    logic check_en;
    logic col_dec;
    logic out_ld;
  } uop_t;

  typedef struct packed {
    uop_t  uop;
    cond_e cond;
    step_e target;
  } ucode_t;

  typedef struct packed {
    logic test_go;
    logic mag_zero;
    logic col_end;
    logic prime_bad;
    logic div_busy;
    logic div_more;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input step_e s);
    ucode_t w;
    w = '0;
    w.cond = C_NEVER;
    w.target = ST_IDLE;
    case (s)
      ST_IDLE: begin
        w.uop.accept = 1'b1;
        w.cond = C_NO_TEST;
        w.target = ST_IDLE;
      end
      ST_MUL: begin
        w.uop.mul_en = 1'b1;
      end
      ST_SUB: begin
        w.uop.sub_en = 1'b1;
        w.cond = C_MAG_ZERO;
        w.target = ST_DONE;
      end
      ST_COL: begin
        w.uop.rd_en = 1'b1;
        w.cond = C_COL_END;
        w.target = ST_DONE;
      end
      ST_PRIME: begin
        w.cond = C_PRIME_BAD;
        w.target = ST_NEXT;
      end
      ST_DIVST: begin
        w.uop.div_start = 1'b1;
      end
      ST_DIVRUN: begin
        w.uop.div_step = 1'b1;
        w.cond = C_DIV_BUSY;
        w.target = ST_DIVRUN;
      end
      ST_CHECK: begin
        w.uop.check_en = 1'b1;
        w.cond = C_DIV_MORE;
        w.target = ST_DIVST;
      end
      ST_NEXT: begin
        w.uop.col_dec = 1'b1;
        w.cond = C_ALWAYS;
        w.target = ST_COL;
      end
      ST_DONE: begin
        w.uop.out_ld = 1'b1;
        w.cond = C_OUT_FULL;
        w.target = ST_DONE;
      end
      ST_RET: begin
        w.cond = C_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/spv_chan_if.sv
interface spv_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/spv_div.sv
module spv_div #(
  parameter int MAG_W = 34
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spv_pkg::div_ctrl_t          ctrl_i,
  input  logic [MAG_W-1:0]            dividend_i,
  input  logic [spv_pkg::PRIME_W-1:0] divisor_i,
  output logic [MAG_W-1:0]            quot_o,
  output logic [spv_pkg::PRIME_W-1:0] rem_o,
  output logic                        last_o
);

  localparam int NGRP = (MAG_W + spv_pkg::RADIX - 1) / spv_pkg::RADIX;
  localparam int DW   = NGRP * spv_pkg::RADIX;
  localparam int CW   = (NGRP > 1) ? $clog2(NGRP) : 1;

  logic [DW-1:0]               q_q, q_n;
  logic [spv_pkg::PRIME_W:0]   r_q, r_n;
  logic [spv_pkg::PRIME_W-1:0] d_q;
  logic [CW-1:0]               cnt_q;

  // restoring division, RADIX quotient bits per cycle while step is asserted
  always_comb begin
    r_n = r_q;
    q_n = q_q;
    for (int i = 0; i < spv_pkg::RADIX; i++) begin
      r_n = {r_n[spv_pkg::PRIME_W-1:0], q_n[DW-1]};
      q_n = {q_n[DW-2:0], 1'b0};
      if (r_n >= {1'b0, d_q}) begin
        r_n = r_n - {1'b0, d_q};
        q_n[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.start) begin
      cnt_q <= '0;
    end else if (ctrl_i.step) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      q_q <= DW'(dividend_i);
      r_q <= '0;
      d_q <= divisor_i;
    end else if (ctrl_i.step) begin
      q_q <= q_n;
      r_q <= r_n;
    end
  end

  assign quot_o = MAG_W'(q_q);
  assign rem_o  = spv_pkg::PRIME_W'(r_q);
  assign last_o = (cnt_q == CW'(NGRP - 1));

endmodule

// File: hw/rtl/spv_seq.sv
module spv_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spv_pkg::stat_t stat_i,
  output spv_pkg::uop_t  uop_o
);

  spv_pkg::step_e  pc_q, pc_d;
  spv_pkg::ucode_t word;
  logic            take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= spv_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_comb begin
    word = spv_pkg::ucode_rom(pc_q);
    case (word.cond)
      spv_pkg::C_NEVER:     take = 1'b0;
      spv_pkg::C_ALWAYS:    take = 1'b1;
      spv_pkg::C_NO_TEST:   take = !stat_i.test_go;
      spv_pkg::C_MAG_ZERO:  take = stat_i.mag_zero;
      spv_pkg::C_COL_END:   take = stat_i.col_end;
      spv_pkg::C_PRIME_BAD: take = stat_i.prime_bad;
      spv_pkg::C_DIV_BUSY:  take = stat_i.div_busy;
      spv_pkg::C_DIV_MORE:  take = stat_i.div_more;
      spv_pkg::C_OUT_FULL:  take = stat_i.out_full;
      default:              take = 1'b1;
    endcase
    pc_d  = take ? word.target : spv_pkg::step_e'(pc_q + 4'd1);
    uop_o = word.uop;
  end

endmodule

// File: hw/rtl/spv_dp.sv
module spv_dp #(
  parameter int BASE_SIZE = spv_pkg::BASE_SIZE_DEF,
  parameter int CAND_BITS = spv_pkg::CAND_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  spv_chan_if.sink       in_i,
  spv_chan_if.sink       cfg_i,
  spv_chan_if.source     out_o,
  input  spv_pkg::uop_t  uop_i,
  output spv_pkg::stat_t stat_o
);

  localparam int DEPTH = BASE_SIZE - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SQ_W  = 2 * CAND_BITS;
  localparam int MAG_W = (SQ_W > spv_pkg::N_W) ? SQ_W : spv_pkg::N_W;

  logic [spv_pkg::N_W-1:0]     n_q;
  logic [spv_pkg::CNT_W-1:0]   pcount_q;
  logic [CAND_BITS-1:0]        x_q;
  logic [SQ_W-1:0]             sq_q;
  logic [MAG_W-1:0]            mag_q;
  logic [spv_pkg::PAR_W-1:0]   bits_q;
  logic [spv_pkg::SLOT_W-1:0]  col_q;
  logic [spv_pkg::PRIME_W-1:0] rd_q;
  logic [spv_pkg::PRIME_W-1:0] mem_q [DEPTH];
  logic                        out_valid_q;
  spv_pkg::out_item_t          out_q;

  logic                        in_fire, cfg_fire, out_fire;
  logic [MAG_W-1:0]            sq_ext, n_ext, mag_d;
  logic                        neg;
  logic [spv_pkg::SLOT_W-1:0]  cols;
  logic [AW-1:0]               rd_addr;
  logic [MAG_W-1:0]            div_quot;
  logic [spv_pkg::PRIME_W-1:0] div_rem;
  logic                        div_last;
  logic                        rem_zero;
  spv_pkg::div_ctrl_t          div_ctrl;

  assign in_i.ready  = uop_i.accept;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;

  assign sq_ext = MAG_W'(sq_q);
  assign n_ext  = MAG_W'(n_q);
  assign neg    = sq_ext < n_ext;
  assign mag_d  = neg ? (n_ext - sq_ext) : (sq_ext - n_ext);
  assign cols   = (pcount_q > spv_pkg::SLOT_W'(DEPTH)) ? spv_pkg::SLOT_W'(DEPTH) : pcount_q;
  assign rd_addr  = AW'(col_q - spv_pkg::SLOT_W'(1));
  assign rem_zero = (div_rem == '0);

  assign div_ctrl.start = uop_i.div_start;
  assign div_ctrl.step  = uop_i.div_step;

  spv_div #(
    .MAG_W (MAG_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (mag_q),
    .divisor_i  (rd_q),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .last_o     (div_last)
  );

  always_comb begin
    stat_o.test_go   = in_fire && (in_i.payload.action == spv_pkg::ACT_TEST);
    stat_o.mag_zero  = (sq_ext == n_ext);
    stat_o.col_end   = (col_q == '0) || (mag_q <= MAG_W'(1));
    stat_o.prime_bad = (rd_q < spv_pkg::PRIME_W'(2));
    stat_o.div_busy  = !div_last;
    stat_o.div_more  = rem_zero && (div_quot > MAG_W'(1));
    stat_o.out_full  = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      pcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        if (cfg_i.payload.index == spv_pkg::REG_N_VALUE) begin
          n_q <= cfg_i.payload.data;
        end else if (cfg_i.payload.index == spv_pkg::REG_PRIME_COUNT) begin
          pcount_q <= spv_pkg::CNT_W'(cfg_i.payload.data);
        end
      end
      if (uop_i.out_ld && !out_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // factor base store
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_i.payload.action == spv_pkg::ACT_LOAD) &&
        (in_i.payload.slot < spv_pkg::SLOT_W'(DEPTH))) begin
      mem_q[AW'(in_i.payload.slot)] <= in_i.payload.prime;
    end
    if (uop_i.rd_en && (col_q != '0)) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (in_i.payload.action == spv_pkg::ACT_TEST)) begin
      x_q <= CAND_BITS'(in_i.payload.candidate);
    end
    if (uop_i.mul_en) begin
      sq_q <= x_q * x_q;
    end
    if (uop_i.sub_en) begin
      mag_q  <= mag_d;
      bits_q <= {{(spv_pkg::PAR_W-1){1'b0}}, neg};
      col_q  <= cols;
    end else if (uop_i.check_en && rem_zero) begin
      mag_q         <= div_quot;
      bits_q[col_q] <= ~bits_q[col_q];
    end else if (uop_i.col_dec) begin
      col_q <= col_q - spv_pkg::SLOT_W'(1);
    end
    if (uop_i.out_ld && !out_valid_q) begin
      out_q.smooth         <= (mag_q == MAG_W'(1));
      out_q.parity_bits    <= (mag_q == '0) ? '0 : bits_q;
      out_q.cofactor       <= spv_pkg::COF_W'(mag_q);
      out_q.candidate_echo <= spv_pkg::CAND_W'(x_q);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

// File: hw/rtl/smoothness_parity_vector.sv
// load item: taken whenever the sequencer is idle; it gives no result
// test item: square, |x*x - N| (zero goes straight to the result), then for each
// column a prime read and trial divisions of NGRP = ceil(max(2*CAND_BITS,32)/4) steps
// back to idle after the result loads; loading waits while the output is full
// reset (async, active low) clears step/divider counters, N, prime count, output valid
// the factor base memory is not cleared and holds garbage until loaded
module smoothness_parity_vector #(
  parameter int BASE_SIZE = spv_pkg::BASE_SIZE_DEF,
  parameter int CAND_BITS = spv_pkg::CAND_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spv_chan_if.sink   in_i,
  spv_chan_if.sink   cfg_i,
  spv_chan_if.source out_o
);

  spv_pkg::uop_t  uop;
  spv_pkg::stat_t stat;

  spv_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .uop_o  (uop)
  );

  spv_dp #(
    .BASE_SIZE (BASE_SIZE),
    .CAND_BITS (CAND_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .out_o  (out_o),
    .uop_i  (uop),
    .stat_o (stat)
  );

  a_test_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.payload.action == spv_pkg::ACT_TEST))
      |=> !in_i.ready)
    else $error("sequencer still idle after test transfer");

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uop.out_ld && !stat.out_full) |=> out_o.valid)
    else $error("result not loaded into output register");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(uop.out_ld))
    else $error("output valid without done step");

endmodule
